[src/cfo_pkg.sv]
// Shared types and constants for the core-first ordering block
`default_nettype none
package cfo_pkg;

  localparam int MAX_CPUS = 64;
  localparam int IDX_W    = $clog2(MAX_CPUS);
  localparam int CNT_W    = $clog2(MAX_CPUS + 1);
  localparam int LOC_W    = 16;

  localparam logic [1:0] CLASS_FIRST   = 2'd0;
  localparam logic [1:0] CLASS_DUP     = 2'd1;
  localparam logic [1:0] CLASS_OFFLINE = 2'd2;

  typedef struct packed {
    logic [LOC_W-1:0] loc;
    logic             online;
    logic [1:0]       grp;
  } rec_t;

  typedef struct packed {
    logic load;
    logic seen_rd;
    logic mark_dup;
    logic k_inc;
    logic k_clr;
    logic store;
    logic rec_rd;
    logic emit;
    logic cls_inc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic offline;
    logic full;
    logic last;
    logic seen_end;
    logic seen_hit;
    logic rec_end;
    logic cls_last;
  } status_t;

endpackage
`default_nettype wire

[src/cfo_dp.sv]
// Datapath: record and seen-location memories, counters and result registers
`default_nettype none
module cfo_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cfo_pkg::cmd_t                cmd,
  output cfo_pkg::status_t                  status,
  input  wire logic                         cpu_online,
  input  wire logic signed [cfo_pkg::LOC_W-1:0] cpu_location,
  input  wire logic                         last_cpu,
  output logic                              strobe,
  output logic [cfo_pkg::IDX_W-1:0]         cpu_index,
  output logic signed [cfo_pkg::LOC_W-1:0]  out_location,
  output logic                              out_online,
  output logic [1:0]                        group_class,
  output logic                              last_result
);
  import cfo_pkg::*;

  rec_t             rec_mem [MAX_CPUS];
  logic [LOC_W-1:0] seen_mem [MAX_CPUS];

  logic [LOC_W-1:0] in_loc;
  logic             in_online;
  logic             in_last;
  logic             dup;
  logic [CNT_W-1:0] rec_count;
  logic [CNT_W-1:0] seen_count;
  logic [CNT_W-1:0] emitted;
  logic [CNT_W-1:0] k;
  logic [1:0]       cls;
  logic [LOC_W-1:0] seen_rd_data;
  rec_t             rec_rd_data;
  rec_t             new_rec;

  always_comb begin
    new_rec.loc    = in_loc;
    new_rec.online = in_online;
    if (!in_online) begin
      new_rec.grp = CLASS_OFFLINE;
    end else if (dup) begin
      new_rec.grp = CLASS_DUP;
    end else begin
      new_rec.grp = CLASS_FIRST;
    end
  end

  assign status.offline  = !in_online;
  assign status.full     = (rec_count == CNT_W'(MAX_CPUS));
  assign status.last     = in_last;
  assign status.seen_end = (k == seen_count);
  assign status.seen_hit = (seen_rd_data == in_loc);
  assign status.rec_end  = ((k + CNT_W'(1)) == rec_count);
  assign status.cls_last = (cls == CLASS_OFFLINE);

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_loc    <= cpu_location;
      in_online <= cpu_online;
      in_last   <= last_cpu;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rec_mem[rec_count[IDX_W-1:0]] <= new_rec;
      if (new_rec.grp == CLASS_FIRST && seen_count < CNT_W'(MAX_CPUS)) begin
        seen_mem[seen_count[IDX_W-1:0]] <= in_loc;
      end
    end
    if (cmd.seen_rd) begin
      seen_rd_data <= seen_mem[k[IDX_W-1:0]];
    end
    if (cmd.rec_rd) begin
      rec_rd_data <= rec_mem[k[IDX_W-1:0]];
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_count  <= '0;
      seen_count <= '0;
      emitted    <= '0;
      k          <= '0;
      cls        <= CLASS_FIRST;
      dup        <= 1'b0;
    end else begin
      if (cmd.load) begin
        dup <= 1'b0;
        k   <= '0;
        cls <= CLASS_FIRST;
      end else if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + CNT_W'(1);
      end
      if (cmd.mark_dup) begin
        dup <= 1'b1;
      end
      if (cmd.cls_inc) begin
        cls <= cls + 2'd1;
      end
      if (cmd.store) begin
        rec_count <= rec_count + CNT_W'(1);
        if (new_rec.grp == CLASS_FIRST && seen_count < CNT_W'(MAX_CPUS)) begin
          seen_count <= seen_count + CNT_W'(1);
        end
      end
      if (cmd.emit && rec_rd_data.grp == cls) begin
        emitted <= emitted + CNT_W'(1);
      end
      if (cmd.finish) begin
        rec_count  <= '0;
        seen_count <= '0;
        emitted    <= '0;
      end
    end
  end

  // result registers; one-cycle strobe per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit && (rec_rd_data.grp == cls);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && rec_rd_data.grp == cls) begin
      cpu_index    <= k[IDX_W-1:0];
      out_location <= rec_rd_data.loc;
      out_online   <= rec_rd_data.online;
      group_class  <= cls;
      last_result  <= ((emitted + CNT_W'(1)) == rec_count);
    end
  end

endmodule
`default_nettype wire

[src/cfo_ctrl.sv]
// Controller: sequences search, store and the three emit passes
`default_nettype none
module cfo_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire cfo_pkg::status_t status,
  output cfo_pkg::cmd_t         cmd
);
  import cfo_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_SRCH     = 3'd2;
  localparam logic [2:0] S_CMP      = 3'd3;
  localparam logic [2:0] S_STORE    = 3'd4;
  localparam logic [2:0] S_EMIT_RD  = 3'd5;
  localparam logic [2:0] S_EMIT_CHK = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.full) begin
          state_next = status.last ? S_EMIT_RD : S_IDLE;
        end else if (status.offline) begin
          state_next = S_STORE;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (status.seen_end) begin
          state_next = S_STORE;
        end else begin
          cmd.seen_rd = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (status.seen_hit) begin
          cmd.mark_dup = 1'b1;
          state_next   = S_STORE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_SRCH;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (status.last) begin
          cmd.k_clr  = 1'b1;
          state_next = S_EMIT_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd.rec_rd = 1'b1;
        state_next = S_EMIT_CHK;
      end
      S_EMIT_CHK: begin
        cmd.emit = 1'b1;
        if (!status.rec_end) begin
          cmd.k_inc  = 1'b1;
          state_next = S_EMIT_RD;
        end else if (status.cls_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.cls_inc = 1'b1;
          cmd.k_clr   = 1'b1;
          state_next  = S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[src/cpu_core_first_ordering_top.sv]
// Top level: core-first ordering of processor records
// A record is dropped when the buffer is full and stored without a search when offline;
// an online one is compared with the seen locations, one entry read and compared at a
// time, until a hit or the list end. The marked last record then emits over 3 passes,
// one per class, results strobed for one cycle each and never stalled.
// Synchronous reset empties the set; memory contents are left as they are.
`default_nettype none
module cpu_core_first_ordering_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        cpu_online,
  input  wire logic signed [cfo_pkg::LOC_W-1:0] cpu_location,
  input  wire logic                        last_cpu,
  output logic                             strobe,
  output logic [cfo_pkg::IDX_W-1:0]        cpu_index,
  output logic signed [cfo_pkg::LOC_W-1:0] out_location,
  output logic                             out_online,
  output logic [1:0]                       group_class,
  output logic                             last_result
);
  import cfo_pkg::*;

  cmd_t    cmd;
  status_t status;

  cfo_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  cfo_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cpu_online   (cpu_online),
    .cpu_location (cpu_location),
    .last_cpu     (last_cpu),
    .strobe       (strobe),
    .cpu_index    (cpu_index),
    .out_location (out_location),
    .out_online   (out_online),
    .group_class  (group_class),
    .last_result  (last_result)
  );

endmodule
`default_nettype wire

[bench/cfo_checker.sv]
// Checker for the core-first ordering block: predicts each ordered set and compares results
`timescale 1ns / 1ps
module cfo_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire logic                                cpu_online,
  input  wire logic signed [cfo_pkg::LOC_W-1:0]   cpu_location,
  input  wire logic                                last_cpu,
  input  wire logic                                strobe,
  input  wire logic [cfo_pkg::IDX_W-1:0]          cpu_index,
  input  wire logic signed [cfo_pkg::LOC_W-1:0]   out_location,
  input  wire logic                                out_online,
  input  wire logic [1:0]                          group_class,
  input  wire logic                                last_result,
  output int                                       errors,
  output int                                       pending,
  output int                                       checked
);
  import cfo_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [LOC_W-1:0] loc;
    logic             online;
    logic [1:0]       grp;
    logic             lst;
  } ordered_rec_t;

  ordered_rec_t     ordered_q[$];

  // records of the set being loaded, and the distinct online locations so far
  logic [LOC_W-1:0] held_loc[MAX_CPUS];
  logic             held_online[MAX_CPUS];
  logic [1:0]       held_grp[MAX_CPUS];
  logic [LOC_W-1:0] seen_loc[MAX_CPUS];
  int               n_held = 0;
  int               n_seen = 0;
  int               n_fail = 0;
  int               n_checked = 0;

  function automatic logic location_known(input logic [LOC_W-1:0] loc);
    for (int k = 0; k < n_seen; k++)
      if (seen_loc[k] == loc) return 1'b1;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    n_fail++;
    if (n_fail <= 40)
      $display("[%0t] %s: got %0d, want %0d", $time, field, got, want);
  endtask

  // classify one record; on the last mark, release the set as first/dup/offline
  task automatic absorb_record(input logic onl, input logic [LOC_W-1:0] loc,
                               input logic lst);
    logic [1:0]   grp;
    ordered_rec_t r;
    int           emitted;
    if (n_held < MAX_CPUS) begin
      if (!onl) begin
        grp = CLASS_OFFLINE;
      end else if (location_known(loc)) begin
        grp = CLASS_DUP;
      end else begin
        grp = CLASS_FIRST;
        seen_loc[n_seen] = loc;
        n_seen++;
      end
      held_loc[n_held] = loc;
      held_online[n_held] = onl;
      held_grp[n_held] = grp;
      n_held++;
    end
    if (lst) begin
      emitted = 0;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < n_held; k++) begin
          if (held_grp[k] == c) begin
            r.idx = k[IDX_W-1:0];
            r.loc = held_loc[k];
            r.online = held_online[k];
            r.grp = held_grp[k];
            r.lst = (emitted == n_held - 1);
            ordered_q.push_back(r);
            emitted++;
          end
        end
      end
      n_held = 0;
      n_seen = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    ordered_rec_t want;
    if (rst) begin
      n_held = 0;
      n_seen = 0;
    end else begin
      // results first: nothing accepted at this edge can already show up in them
      if (strobe) begin
        if (ordered_q.size() == 0) begin
          report_mismatch("result with nothing expected, cpu_index", cpu_index, -1);
        end else begin
          want = ordered_q.pop_front();
          n_checked++;
          if (cpu_index !== want.idx)
            report_mismatch("cpu_index", cpu_index, want.idx);
          if (out_location !== want.loc)
            report_mismatch("out_location", out_location, $signed(want.loc));
          if (out_online !== want.online)
            report_mismatch("out_online", out_online, want.online);
          if (group_class !== want.grp)
            report_mismatch("group_class", group_class, want.grp);
          if (last_result !== want.lst)
            report_mismatch("last_result", last_result, want.lst);
        end
      end
      if (start && !busy)
        absorb_record(cpu_online, cpu_location, last_cpu);
    end
    errors <= n_fail;
    pending <= ordered_q.size();
    checked <= n_checked;
  end

endmodule

[bench/tb_top.sv]
// Testbench top: drives record sets into the ordering block and gives the verdict
`timescale 1ns / 1ps
module tb_top;
  import cfo_pkg::*;

  localparam int STALL_LIMIT    = 5000;
  localparam int TARGET_RECORDS = 170;
  localparam int CALM_TAIL      = 30;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    cpu_online = 1'b0;
  logic signed [LOC_W-1:0] cpu_location = '0;
  logic                    last_cpu = 1'b0;
  logic                    busy;
  logic                    strobe;
  logic [IDX_W-1:0]        cpu_index;
  logic signed [LOC_W-1:0] out_location;
  logic                    out_online;
  logic [1:0]              group_class;
  logic                    last_result;

  int errors;
  int pending;
  int checked;
  int records_sent = 0;
  int sets_sent = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  cpu_core_first_ordering_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cpu_online(cpu_online), .cpu_location(cpu_location), .last_cpu(last_cpu),
    .strobe(strobe), .cpu_index(cpu_index), .out_location(out_location),
    .out_online(out_online), .group_class(group_class), .last_result(last_result)
  );

  cfo_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cpu_online(cpu_online), .cpu_location(cpu_location), .last_cpu(last_cpu),
    .strobe(strobe), .cpu_index(cpu_index), .out_location(out_location),
    .out_online(out_online), .group_class(group_class), .last_result(last_result),
    .errors(errors), .pending(pending), .checked(checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("cpu_core_first_ordering_top: mismatch");
        $finish;
      end
    end
  end

  // start stays high into the next record unless an idle burst follows
  task automatic send_record(input logic onl, input logic signed [LOC_W-1:0] loc,
                             input logic lst);
    start <= 1'b1;
    cpu_online <= onl;
    cpu_location <= loc;
    last_cpu <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    records_sent++;
    if (lst) sets_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // narrow sets draw from a small pool of locations so duplicates are common
  task automatic random_set(input int size, input bit narrow);
    logic signed [LOC_W-1:0] pool[4];
    logic signed [LOC_W-1:0] loc;
    for (int p = 0; p < 4; p++) pool[p] = LOC_W'($urandom);
    for (int i = 0; i < size; i++) begin
      loc = narrow ? pool[$urandom_range(0, 3)] : LOC_W'($urandom);
      send_record($urandom_range(0, 3) != 0, loc, i == size - 1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone online record
    send_record(1'b1, 16'sd0, 1'b1);
    // extremes, -1 online, offline with odd locations, duplicates of each
    send_record(1'b1, 16'sh7fff, 1'b0);
    send_record(1'b1, -16'sh8000, 1'b0);
    send_record(1'b1, -16'sd1, 1'b0);
    send_record(1'b0, -16'sd1, 1'b0);
    send_record(1'b1, 16'sh7fff, 1'b0);
    send_record(1'b0, 16'sd12345, 1'b0);
    send_record(1'b1, -16'sd1, 1'b0);
    send_record(1'b1, -16'sh8000, 1'b0);
    send_record(1'b0, 16'sd0, 1'b1);
    // lone offline record
    send_record(1'b0, 16'sh5555, 1'b1);
    // new set: 1 is a first user, then a duplicate
    send_record(1'b1, 16'sd1, 1'b0);
    send_record(1'b1, 16'sd1, 1'b0);
    send_record(1'b0, -16'sh8000, 1'b0);
    send_record(1'b1, 16'sd2, 1'b1);

    random_set($urandom_range(2, 8), 1'b1);
    random_set($urandom_range(2, 8), 1'b0);
    // overfilled set: records past the buffer are dropped, the last one included
    random_set(MAX_CPUS + $urandom_range(1, 3), 1'b1);

    while (records_sent < TARGET_RECORDS) begin
      if (records_sent >= TARGET_RECORDS - CALM_TAIL) calm = 1'b1;
      random_set($urandom_range(1, 10), $urandom_range(0, 3) != 0);
    end

    start <= 1'b0;
    last_cpu <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("sent %0d records in %0d sets, one set overfilled past %0d entries",
             records_sent, sets_sent, MAX_CPUS);
    $display("checked %0d ordered results, %0d field errors", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("cpu_core_first_ordering_top: match");
    end else begin
      $display("cpu_core_first_ordering_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
src/cfo_pkg.sv
src/cfo_dp.sv
src/cfo_ctrl.sv
src/cpu_core_first_ordering_top.sv
bench/cfo_checker.sv
bench/tb_top.sv
